/* rtl/analog_ladder_button_debounce_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the ladder keypad decoder
// Concurrent checks clocked on clk and disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef ANALOG_LADDER_BUTTON_DEBOUNCE_DEFINES_SVH
`define ANALOG_LADDER_BUTTON_DEBOUNCE_DEFINES_SVH

// Same-cycle implication.
`define ALBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("albd: same-cycle check failed");

// Next-cycle implication.
`define ALBD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("albd: next-cycle check failed");

`endif

/* rtl/albd_pkg.sv */
// -----------------------------------------------------------------------------
// albd_pkg
// Shared widths, defaults and types for the ladder keypad decoder.
// -----------------------------------------------------------------------------
package albd_pkg;

	localparam int CH_W      = 3;   // channel field width
	localparam int SMP_W     = 12;  // ADC sample width
	localparam int LVL_W     = 12;  // one button level
	localparam int CFG_W     = 63;  // one level register
	localparam int CFG_IDX_W = 3;   // register index width
	localparam int USED_LSB  = 60;  // used level count position
	localparam int USED_W    = 3;
	localparam int CNT_W     = 3;   // debounce counter width
	localparam int PRESS_W   = 5;   // pressed mask width
	localparam int CMP_W     = 13;  // sample plus window, no overflow

	localparam int CHANNELS_DEF           = 8;
	localparam int LEVELS_PER_CHANNEL_DEF = 5;
	localparam int WINDOW_DEF             = 100;
	localparam int DEBOUNCE_DEF           = 5;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             flag;
	} slot_state_t;

endpackage

/* rtl/albd_cfg_regs.sv */
// -----------------------------------------------------------------------------
// albd_cfg_regs
// Per-channel level registers with one write port and one channel read port.
// -----------------------------------------------------------------------------
module albd_cfg_regs #(
	parameter int CHANNELS           = albd_pkg::CHANNELS_DEF,
	parameter int LEVELS_PER_CHANNEL = albd_pkg::LEVELS_PER_CHANNEL_DEF,
	localparam int CH_IW             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [albd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [albd_pkg::CFG_W-1:0]     wr_data,
	input  logic [CH_IW-1:0]              rd_ch,
	output logic [albd_pkg::LVL_W-1:0]     rd_level [LEVELS_PER_CHANNEL],
	output logic [albd_pkg::USED_W-1:0]    rd_used
);

	logic [albd_pkg::CFG_W-1:0] regs_q [CHANNELS];
	logic                       wr_hit;

	// Indexes past the implemented channels are dropped.
	assign wr_hit = wr_en && ({1'b0, wr_index} < (albd_pkg::CFG_IDX_W+1)'(CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_hit) begin
			regs_q[wr_index[CH_IW-1:0]] <= wr_data;
		end
	end

	for (genvar k = 0; k < LEVELS_PER_CHANNEL; k++) begin : g_lvl
		assign rd_level[k] = regs_q[rd_ch][albd_pkg::LVL_W*k +: albd_pkg::LVL_W];
	end

	assign rd_used = regs_q[rd_ch][albd_pkg::USED_LSB +: albd_pkg::USED_W];

endmodule

/* rtl/albd_slot.sv */
// -----------------------------------------------------------------------------
// albd_slot
// Window test and debounce counter update for one button level slot.
// -----------------------------------------------------------------------------
module albd_slot #(
	parameter int WINDOW   = albd_pkg::WINDOW_DEF,
	parameter int DEBOUNCE = albd_pkg::DEBOUNCE_DEF
) (
	input  logic [albd_pkg::LVL_W-1:0] level,
	input  logic [albd_pkg::SMP_W-1:0] sample,
	input  albd_pkg::slot_state_t      cur,
	output albd_pkg::slot_state_t      nxt
);

	localparam logic [albd_pkg::CMP_W-1:0] WIN = albd_pkg::CMP_W'(WINDOW);
	localparam logic [albd_pkg::CNT_W-1:0] DEB = albd_pkg::CNT_W'(DEBOUNCE);

	logic [albd_pkg::CMP_W-1:0] smp_x;
	logic [albd_pkg::CMP_W-1:0] lvl_x;
	logic                       in_win;
	logic [albd_pkg::CNT_W-1:0] cnt_n;

	// Clamping the window to the ADC range never changes the outcome,
	// because the sample itself always lies in that range.
	assign smp_x  = {1'b0, sample};
	assign lvl_x  = {1'b0, level};
	assign in_win = (smp_x + WIN >= lvl_x) && (smp_x <= lvl_x + WIN);

	always_comb begin
		nxt = cur;
		if (in_win) begin
			cnt_n = (cur.cnt < DEB) ? cur.cnt + 1'b1 : cur.cnt;
			if (cnt_n == DEB) begin
				nxt.flag = 1'b1;
			end
		end else begin
			cnt_n = (cur.cnt != '0) ? cur.cnt - 1'b1 : cur.cnt;
			if (cnt_n == '0) begin
				nxt.flag = 1'b0;
			end
		end
		nxt.cnt = cnt_n;
	end

endmodule

/* rtl/analog_ladder_button_debounce.sv */
// -----------------------------------------------------------------------------
// analog_ladder_button_debounce
// Resistor ladder keypad decoder with per-button debounce for several channels.
// -----------------------------------------------------------------------------
// Usage:
// An input beat carries one ADC sample and the channel it came from, on
// in_valid / in_ready. Each input beat yields exactly one output beat on
// out_valid / out_ready, carrying the channel and its debounced pressed mask.
// The input beat lands in an input register; when the result register is free
// or being emptied, the slot lanes update that channel's counters and flags
// and the result register loads the channel and its pressed mask.
// One beat is taken every cycle while out_ready is high: the result register
// and the input register are separate, and in_ready stays high whenever the
// input register drains. If the receiver stalls, the result holds, one more
// beat waits in the input register and in_ready drops until out_ready returns.
// Level registers are written on cfg_valid / cfg_ready (always ready), one
// register per channel; write them only while no beats are in flight.
// Reset clears all level registers, counters and pressed flags at once.
// Samples for channels past CHANNELS leave the state untouched and report
// an empty mask.
// -----------------------------------------------------------------------------
`include "analog_ladder_button_debounce_defines.svh"

module analog_ladder_button_debounce #(
	parameter int CHANNELS           = albd_pkg::CHANNELS_DEF,
	parameter int LEVELS_PER_CHANNEL = albd_pkg::LEVELS_PER_CHANNEL_DEF,
	parameter int WINDOW             = albd_pkg::WINDOW_DEF,
	parameter int DEBOUNCE           = albd_pkg::DEBOUNCE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Sample channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [albd_pkg::CH_W-1:0]      channel,
	input  logic [albd_pkg::SMP_W-1:0]     sample,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [albd_pkg::CH_W-1:0]      out_channel,
	output logic [albd_pkg::PRESS_W-1:0]   pressed,
	// Configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [albd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [albd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [albd_pkg::USED_W-1:0] LEV_MAX = albd_pkg::USED_W'(LEVELS_PER_CHANNEL);

	// Input register.
	logic                       v_s1;
	logic [albd_pkg::CH_W-1:0]  ch_s1;
	logic [albd_pkg::SMP_W-1:0] smp_s1;

	// Result register.
	logic                         out_valid_q;
	logic [albd_pkg::CH_W-1:0]    out_channel_q;
	logic [albd_pkg::PRESS_W-1:0] pressed_q;

	// Debounce state, one row of slots per channel.
	albd_pkg::slot_state_t state_q [CHANNELS][LEVELS_PER_CHANNEL];

	logic                        in_fire;
	logic                        fire;
	logic                        ch_ok;
	logic [CH_IW-1:0]            ch_idx;
	logic [albd_pkg::LVL_W-1:0]  lvl   [LEVELS_PER_CHANNEL];
	logic [albd_pkg::USED_W-1:0] used_raw;
	logic [albd_pkg::USED_W-1:0] used;
	logic [LEVELS_PER_CHANNEL-1:0] slot_on;
	albd_pkg::slot_state_t       cur   [LEVELS_PER_CHANNEL];
	albd_pkg::slot_state_t       nxt   [LEVELS_PER_CHANNEL];
	logic [albd_pkg::PRESS_W-1:0] mask;
	logic                        out_ch_absent;

	// The input register moves forward whenever the result register is free
	// or is being emptied in this cycle.
	assign fire     = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1  <= channel;
			smp_s1 <= sample;
		end
	end

	assign cfg_ready = 1'b1;

	albd_cfg_regs #(
		.CHANNELS          (CHANNELS),
		.LEVELS_PER_CHANNEL(LEVELS_PER_CHANNEL)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.rd_ch   (ch_idx),
		.rd_level(lvl),
		.rd_used (used_raw)
	);

	assign ch_ok  = ({1'b0, ch_s1} < (albd_pkg::CH_W+1)'(CHANNELS));
	assign ch_idx = ch_s1[CH_IW-1:0];

	// A used count above the slot count is treated as the slot count.
	assign used = (used_raw > LEV_MAX) ? LEV_MAX : used_raw;

	for (genvar k = 0; k < LEVELS_PER_CHANNEL; k++) begin : g_slot
		assign cur[k]     = state_q[ch_idx][k];
		assign slot_on[k] = ch_ok && (albd_pkg::USED_W'(k) < used);

		albd_slot #(
			.WINDOW  (WINDOW),
			.DEBOUNCE(DEBOUNCE)
		) u_slot (
			.level (lvl[k]),
			.sample(smp_s1),
			.cur   (cur[k]),
			.nxt   (nxt[k])
		);
	end

	// Only used slots report; unused and missing slots read zero.
	always_comb begin
		mask = '0;
		for (int k = 0; k < LEVELS_PER_CHANNEL; k++) begin
			mask[k] = slot_on[k] && nxt[k].flag;
		end
	end

	// State of the used slots is committed as the beat moves on, so the next
	// beat for the same channel already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < LEVELS_PER_CHANNEL; k++) begin
					state_q[c][k] <= '0;
				end
			end
		end else if (fire) begin
			for (int k = 0; k < LEVELS_PER_CHANNEL; k++) begin
				if (slot_on[k]) begin
					state_q[ch_idx][k] <= nxt[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_channel_q <= ch_s1;
			pressed_q     <= mask;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign pressed     = pressed_q;

	assign out_ch_absent = ({1'b0, out_channel} >= (albd_pkg::CH_W+1)'(CHANNELS));

	// A beat leaving the input register always shows up as a result.
	`ALBD_ASSERT_NXT(a_fire_to_out, fire, out_valid_q)

	// Channels that are not built never report a pressed button.
	`ALBD_ASSERT_IMP(a_absent_ch_empty, out_valid_q && out_ch_absent, pressed_q == '0)

	// A full counter always carries a set flag and an empty one a clear flag.
	for (genvar k = 0; k < LEVELS_PER_CHANNEL; k++) begin : g_chk
		logic flag_cnt_ok;
		assign flag_cnt_ok =
			((cur[k].cnt != albd_pkg::CNT_W'(DEBOUNCE)) || cur[k].flag) &&
			((cur[k].cnt != '0) || !cur[k].flag);
		`ALBD_ASSERT_IMP(a_flag_cnt, v_s1 && ch_ok, flag_cnt_ok)
	end

endmodule

/* tb/albd_scoreboard.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// albd_scoreboard
// Watches the sample, result and level register channels of the ladder keypad
// decoder, keeps its own copy of the debounce state, and checks every result
// beat against the pressed mask that the accepted sample should produce.
// -----------------------------------------------------------------------------
module albd_scoreboard
	import albd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CH_W-1:0]      channel,
	input  logic [SMP_W-1:0]     sample,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [CH_W-1:0]      out_channel,
	input  logic [PRESS_W-1:0]   pressed,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          fault_count,
	output int unsigned          outstanding
);

	localparam int NUM_CH   = CHANNELS_DEF;
	localparam int NUM_LVL  = LEVELS_PER_CHANNEL_DEF;
	localparam int NUM_SLOT = NUM_CH * NUM_LVL;
	localparam int ADC_MAX  = (1 << SMP_W) - 1;

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic [PRESS_W-1:0] mask;
	} key_report_t;

	logic [CFG_W-1:0] ladder_cfg [NUM_CH];
	logic [CNT_W-1:0] hold_cnt [NUM_SLOT];
	logic             key_down [NUM_SLOT];
	key_report_t      reports_due [$];

	// Advances the debounce counters of one channel and returns its pressed mask.
	function automatic logic [PRESS_W-1:0] scan_ladder(input logic [CH_W-1:0] ch,
			input logic [SMP_W-1:0] smp);
		logic [CFG_W-1:0]   word;
		logic [PRESS_W-1:0] mask;
		int                 used;
		int                 lvl;
		int                 lo;
		int                 hi;
		int                 slot;
		mask = '0;
		if (int'(ch) < NUM_CH) begin
			word = ladder_cfg[ch];
			used = int'(word[USED_LSB +: USED_W]);
			if (used > NUM_LVL) used = NUM_LVL;
			for (int k = 0; k < used; k++) begin
				slot = int'(ch) * NUM_LVL + k;
				lvl  = int'(word[k*LVL_W +: LVL_W]);
				lo   = (lvl - WINDOW_DEF < 0) ? 0 : lvl - WINDOW_DEF;
				hi   = (lvl + WINDOW_DEF > ADC_MAX) ? ADC_MAX : lvl + WINDOW_DEF;
				if (int'(smp) >= lo && int'(smp) <= hi) begin
					if (int'(hold_cnt[slot]) < DEBOUNCE_DEF) hold_cnt[slot]++;
					if (int'(hold_cnt[slot]) == DEBOUNCE_DEF) key_down[slot] = 1'b1;
				end else begin
					if (hold_cnt[slot] != '0) hold_cnt[slot]--;
					if (hold_cnt[slot] == '0) key_down[slot] = 1'b0;
				end
				mask[k] = key_down[slot];
			end
		end
		return mask;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_report_t due;
		key_report_t fresh;
		if (!arst_n) begin
			foreach (ladder_cfg[i]) ladder_cfg[i] = '0;
			foreach (hold_cnt[i]) begin
				hold_cnt[i] = '0;
				key_down[i] = 1'b0;
			end
			reports_due.delete();
			fault_count = 0;
			outstanding = 0;
		end else begin
			// Result side first, so a beat that arrives with nothing pending is caught
			// even when a sample is accepted at the same edge.
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%t: result beat ch %0d mask %b with nothing pending",
							$realtime, out_channel, pressed);
				end else begin
					due = reports_due.pop_front();
					if (out_channel !== due.ch || pressed !== due.mask) begin
						fault_count++;
						if (fault_count <= 10)
							$display("%t: expected ch %0d mask %b, got ch %0d mask %b",
								$realtime, due.ch, due.mask, out_channel, pressed);
					end
				end
			end
			if (in_valid && in_ready) begin
				fresh.ch   = channel;
				fresh.mask = scan_ladder(channel, sample);
				reports_due.push_back(fresh);
			end
			if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_CH)
				ladder_cfg[cfg_index] = cfg_data;
			outstanding = unsigned'(reports_due.size());
		end
	end

endmodule

/* tb/tb_analog_ladder_button_debounce.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_analog_ladder_button_debounce
// Drives ADC samples, level register writes and result back-pressure into the
// ladder keypad decoder; a scoreboard beside it predicts and checks each result.
// -----------------------------------------------------------------------------
module tb_analog_ladder_button_debounce;
	import albd_pkg::*;

	localparam int NUM_CH       = CHANNELS_DEF;
	localparam int NUM_LVL      = LEVELS_PER_CHANNEL_DEF;
	localparam int ADC_MAX      = (1 << SMP_W) - 1;
	localparam int IDLE_PCT     = 27;
	localparam int PHASE_ITEMS  = 130;
	localparam int LAST_PHASE   = 5;
	localparam int CALM_PHASE   = 2;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [CH_W-1:0]      channel   = '0;
	logic [SMP_W-1:0]     sample    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CH_W-1:0]      out_channel;
	logic [PRESS_W-1:0]   pressed;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int unsigned fault_count;
	int unsigned outstanding;

	// When set, neither the sample sender nor the result receiver ever idles.
	bit calm = 1'b0;

	// The stimulus keeps its own copy of the level registers so that it can aim
	// sample runs at the buttons that are actually configured.
	logic [CFG_W-1:0] ladder_words [NUM_CH];

	analog_ladder_button_debounce i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.pressed     (pressed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	albd_scoreboard i_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.pressed     (pressed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fault_count (fault_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls on roughly a quarter of the cycles, except in the calm
	// stretch, so that back-pressure lands on every stage of the pipeline.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Packs five button levels and a used count into one register word.
	function automatic logic [CFG_W-1:0] pack_ladder(input int l0, input int l1, input int l2,
			input int l3, input int l4, input int used);
		logic [CFG_W-1:0] word;
		word = '0;
		word[0*LVL_W +: LVL_W]      = LVL_W'(l0);
		word[1*LVL_W +: LVL_W]      = LVL_W'(l1);
		word[2*LVL_W +: LVL_W]      = LVL_W'(l2);
		word[3*LVL_W +: LVL_W]      = LVL_W'(l3);
		word[4*LVL_W +: LVL_W]      = LVL_W'(l4);
		word[USED_LSB +: USED_W]    = USED_W'(used);
		return word;
	endfunction

	// Random register word. Half of the time the levels are bunched together so
	// that neighboring windows overlap and one sample hits several buttons.
	function automatic logic [CFG_W-1:0] random_ladder();
		logic [CFG_W-1:0] word;
		int               base;
		int               stride;
		int               lvl;
		word = CFG_W'({$urandom, $urandom});
		if ($urandom_range(1) == 1) begin
			base   = $urandom_range(ADC_MAX);
			stride = $urandom_range(20, 250);
			for (int k = 0; k < NUM_LVL; k++) begin
				lvl = base + k * stride;
				word[k*LVL_W +: LVL_W] = LVL_W'((lvl > ADC_MAX) ? ADC_MAX : lvl);
			end
		end
		if ($urandom_range(99) < 70)
			word[USED_LSB +: USED_W] = USED_W'($urandom_range(1, NUM_LVL));
		return word;
	endfunction

	// A sample around a level: mostly inside its window, sometimes just outside,
	// now and then well away from it.
	function automatic int near_level(input int lvl);
		int spread;
		int s;
		spread = ($urandom_range(99) < 85) ? WINDOW_DEF + 4 : 3 * WINDOW_DEF;
		s = lvl + int'($urandom_range(0, 2 * spread)) - spread;
		if (s < 0) s = 0;
		if (s > ADC_MAX) s = ADC_MAX;
		return s;
	endfunction

	// Offers one sample beat and returns at the edge where it is taken.
	task automatic send_sample(input int ch, input int smp);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		channel  <= CH_W'(ch);
		sample   <= SMP_W'(smp);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops sending and waits until every result has been checked. Every
	// sample yields a result, so an empty store means the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Writes all level registers from the stimulus copy, back to back.
	task automatic load_ladders();
		for (int i = 0; i < NUM_CH; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= ladder_words[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		int ch;
		int used;
		int slot;
		int lvl;
		int run;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With every register at its reset value no button is in use, so the
		// masks must read empty whatever the sample.
		send_sample(0, 0);
		send_sample(7, ADC_MAX);
		drain();

		// Edge configuration: windows clamped at both rails, a used count above
		// five, an unused channel with junk levels, an all-ones register.
		ladder_words[0] = pack_ladder(0, ADC_MAX, 2048, WINDOW_DEF, ADC_MAX - WINDOW_DEF, 5);
		ladder_words[1] = pack_ladder(1000, 1050, 1100, 1150, 1200, 7);
		ladder_words[2] = pack_ladder(2048, 2048, 2048, 2048, 2048, 0);
		ladder_words[3] = pack_ladder(ADC_MAX, 0, 0, 0, 0, 1);
		ladder_words[4] = pack_ladder(0, 0, 0, 0, 0, 6);
		ladder_words[5] = pack_ladder(50, 4050, 0, 0, 0, 2);
		ladder_words[6] = pack_ladder(1, ADC_MAX - 1, 2000, 0, 0, 3);
		ladder_words[7] = '1;
		load_ladders();

		// Press the two low buttons of channel 0, then probe the edge of the
		// narrow clamped window and walk the count back down to a release.
		repeat (5) send_sample(0, 0);
		send_sample(0, WINDOW_DEF);
		send_sample(0, WINDOW_DEF + 1);
		repeat (4) send_sample(0, ADC_MAX);
		send_sample(0, ADC_MAX - 2 * WINDOW_DEF - 1);
		// One sample sits in all five overlapping windows of channel 1.
		repeat (5) send_sample(1, 1100);
		send_sample(2, 2048);
		send_sample(3, ADC_MAX - WINDOW_DEF);
		send_sample(4, WINDOW_DEF);
		send_sample(7, ADC_MAX);
		send_sample(7, ADC_MAX - WINDOW_DEF - 1);
		drain();

		for (int phase = 1; phase <= LAST_PHASE; phase++) begin
			if (phase == LAST_PHASE) begin
				// Opposite extremes side by side: all ones, and all levels at zero.
				for (int i = 0; i < NUM_CH; i++)
					ladder_words[i] = (i % 2 == 0) ? '1 : pack_ladder(0, 0, 0, 0, 0, NUM_LVL);
			end else begin
				for (int i = 0; i < NUM_CH; i++) ladder_words[i] = random_ladder();
			end
			load_ladders();
			calm = (phase == CALM_PHASE);

			// Mostly runs of samples aimed at one configured button, which is what
			// pushes counters to the press and release limits; the rest is noise.
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				ch   = $urandom_range(NUM_CH - 1);
				used = int'(ladder_words[ch][USED_LSB +: USED_W]);
				if (used > NUM_LVL) used = NUM_LVL;
				if (used == 0 || $urandom_range(99) < 15) begin
					send_sample($urandom_range(NUM_CH - 1), $urandom_range(ADC_MAX));
					sent++;
				end else begin
					slot = $urandom_range(used - 1);
					lvl  = int'(ladder_words[ch][slot*LVL_W +: LVL_W]);
					run  = $urandom_range(1, 8);
					repeat (run) begin
						send_sample(ch, near_level(lvl));
						sent++;
					end
				end
			end
			drain();
			calm = 1'b0;
		end

		// Let any stray result beat show up before the verdict.
		repeat (20) @(negedge clk);
		if (fault_count == 0 && outstanding == 0) begin
			$display("tb_analog_ladder_button_debounce: clean");
		end else begin
			$display("tb_analog_ladder_button_debounce: errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("tb_analog_ladder_button_debounce: errors");
		$finish;
	end

endmodule
